// ===== rtl/cheb_pkg.sv =====
// Types and constants shared by the Chebyshev series evaluator.
package cheb_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam int COEF_W = 32;
    localparam int ARG_W  = 32;
    localparam int ACC_W  = 48;
    localparam int DEG_W  = 6;
    localparam int IDX_IN_W = 6;
    localparam int FRAC_SHIFT = 29;

    localparam logic signed [ARG_W-1:0] T_ONE = 32'sd536870912;

    typedef struct packed {
        logic                        operation;
        logic [IDX_IN_W-1:0]         coefficient_index;
        logic signed [COEF_W-1:0]    coefficient_value;
        logic signed [ARG_W-1:0]     argument;
    } eval_req_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]     series_value;
        logic                        saturated;
    } eval_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } eval_state_t;

endpackage

// ===== rtl/chebyshev_series_evaluator.sv =====
// Chebyshev series evaluator: coefficient memory, recurrence and accumulate pipeline.
//
//  channel   signals                          direction  moves
//  req       req_valid, req_stall, req        in         load or evaluate item
//  rsp       rsp_valid, rsp_stall, rsp        out        series value and saturation flag
//  cfg       cfg_write, cfg_data              in         series_degree
//
//  A load item writes the coefficient memory directly. For an evaluate item, D being the effective
//  degree (1..MAX_TERMS-1), there is one coefficient memory read and one recurrence step per term,
//  then the multiply/accumulate drain and the load of the output register.
//  Reset clears control state and sets series_degree to 1; the coefficient memory is
//  not cleared. A stalled result stays in the output register; the next item is taken
//  while it waits, and a new evaluation finishes only once that register is free.
module chebyshev_series_evaluator
    import cheb_pkg::*;
#(
    parameter int MAX_TERMS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  eval_req_t         req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output eval_rsp_t         rsp,
    input  logic              cfg_write,
    input  logic [DEG_W-1:0]  cfg_data
);

    localparam int IDX_W = (MAX_TERMS > 2) ? $clog2(MAX_TERMS) : 1;
    localparam int WIDE_W = 11;
    localparam int PROD_W = 2 * ARG_W;
    localparam int RND_W = PROD_W - FRAC_SHIFT + 1;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd268435456);
    localparam logic [WIDE_W-1:0] TOP_IDX = WIDE_W'(MAX_TERMS - 1);
    localparam logic [WIDE_W-1:0] TERMS_W = WIDE_W'(MAX_TERMS);
    localparam logic signed [RND_W:0] T_MAX = (RND_W+1)'(64'sd2147483647);
    localparam logic signed [RND_W:0] T_MIN = -(RND_W+1)'(64'sd2147483648);
    localparam logic signed [ACC_W:0] A_MAX = (ACC_W+1)'(64'sd140737488355327);
    localparam logic signed [ACC_W:0] A_MIN = -(ACC_W+1)'(64'sd140737488355328);

    eval_state_t state_reg, state_next;

    logic signed [COEF_W-1:0] coef_mem [MAX_TERMS];
    logic signed [COEF_W-1:0] coef_rd_reg;

    logic [DEG_W-1:0]         series_degree_reg;
    logic [IDX_W-1:0]         deg_reg;
    logic [IDX_W-1:0]         cnt_reg;
    logic signed [ARG_W-1:0]  x_reg;
    logic signed [ARG_W-1:0]  tk_reg;
    logic signed [ARG_W-1:0]  tkm1_reg;
    logic                     s1_valid_reg, s1_last_reg;
    logic signed [ARG_W-1:0]  s1_t_reg;
    logic                     s2_valid_reg, s2_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     sat_reg;
    logic                     rsp_valid_reg;
    eval_rsp_t                rsp_reg;

    logic                     start, issue, load_we, out_load, idx_ok;
    logic [WIDE_W-1:0]        idx_wide, deg_req;
    logic [IDX_W-1:0]         deg_eff;

    logic signed [PROD_W-1:0] rec_prod;
    logic signed [RND_W-1:0]  rec_p;
    logic signed [RND_W:0]    rec_sum;
    logic signed [ARG_W-1:0]  rec_t;
    logic                     rec_ovf;

    logic signed [RND_W-1:0]  term;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  acc_new;
    logic                     acc_ovf;

    assign idx_wide = WIDE_W'(req.coefficient_index);
    assign idx_ok   = idx_wide < TERMS_W;
    assign deg_req  = (series_degree_reg == '0) ? WIDE_W'(1) : WIDE_W'(series_degree_reg);
    assign deg_eff  = (deg_req > TOP_IDX) ? IDX_W'(TOP_IDX) : IDX_W'(deg_req);

    // T_(k+1) = 2*round(x*T_k) - T_(k-1)
    assign rec_prod = x_reg * tk_reg;
    assign rec_p    = RND_W'((rec_prod + RND_HALF) >>> FRAC_SHIFT);
    assign rec_sum  = (RND_W+1)'({rec_p, 1'b0}) - (RND_W+1)'(tkm1_reg);

    always_comb
    begin
        rec_ovf = 1'b1;
        if (rec_sum > T_MAX)
            rec_t = ARG_W'(T_MAX);
        else if (rec_sum < T_MIN)
            rec_t = ARG_W'(T_MIN);
        else
        begin
            rec_t   = ARG_W'(rec_sum);
            rec_ovf = 1'b0;
        end
    end

    assign term    = RND_W'((prod_reg + RND_HALF) >>> FRAC_SHIFT);
    assign acc_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(term);

    always_comb
    begin
        acc_ovf = 1'b1;
        if (acc_sum > A_MAX)
            acc_new = ACC_W'(A_MAX);
        else if (acc_sum < A_MIN)
            acc_new = ACC_W'(A_MIN);
        else
        begin
            acc_new = ACC_W'(acc_sum);
            acc_ovf = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        start      = 1'b0;
        issue      = 1'b0;
        load_we    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.operation == OP_EVAL)
                    begin
                        start      = 1'b1;
                        state_next = ST_ISSUE;
                    end
                    else
                        load_we = idx_ok;
                end
            end
            ST_ISSUE:
            begin
                issue = 1'b1;
                if (cnt_reg == deg_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (s2_valid_reg && s2_last_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            series_degree_reg <= DEG_W'(1);
            s1_valid_reg      <= 1'b0;
            s1_last_reg       <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s2_last_reg       <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s1_last_reg  <= issue && (cnt_reg == deg_reg);
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_valid_reg && s1_last_reg;
            if (cfg_write)
                series_degree_reg <= cfg_data;
            if (out_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
            coef_mem[IDX_W'(idx_wide)] <= req.coefficient_value;
        coef_rd_reg <= coef_mem[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= req.argument;
            tk_reg   <= T_ONE;
            tkm1_reg <= req.argument;
            cnt_reg  <= '0;
            deg_reg  <= deg_eff;
            acc_reg  <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                cnt_reg  <= cnt_reg + IDX_W'(1);
                tk_reg   <= rec_t;
                tkm1_reg <= tk_reg;
            end
            if (s2_valid_reg)
                acc_reg <= acc_new;
            sat_reg <= sat_reg
                | (issue && (cnt_reg != deg_reg) && rec_ovf)
                | (s2_valid_reg && acc_ovf);
        end
        s1_t_reg <= tk_reg;
        prod_reg <= coef_rd_reg * s1_t_reg;
        if (out_load)
        begin
            rsp_reg.series_value <= acc_reg;
            rsp_reg.saturated    <= sat_reg;
        end
    end

endmodule

// ===== bench/tb_chebyshev_series_evaluator.sv =====
// Self-checking testbench for the Chebyshev series evaluator: directed table, random phases.
`timescale 1ns / 100ps

module tb_chebyshev_series_evaluator;
    import cheb_pkg::*;

    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     SETTLE       = 80;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     PHASE_ITEMS  = 150;
    localparam int     PHASES       = 9;
    localparam longint T_HI         = 64'sd2147483647;
    localparam longint T_LO         = -64'sd2147483648;
    localparam longint ACC_HI       = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO       = -(64'sd1 <<< 47);

    typedef struct {
        eval_req_t item;
        bit        typed;
        eval_rsp_t want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    eval_req_t         req = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    eval_rsp_t         rsp;
    logic              cfg_write = 1'b0;
    logic [DEG_W-1:0]  cfg_data = '0;

    logic signed [COEF_W-1:0] coef_table [64];
    bit                       coef_loaded [64];
    logic [DEG_W-1:0]         degree_reg = 1;
    eval_rsp_t                pending_sums [$];
    stim_row_t                stim_table [$];
    int                       mismatches = 0;
    int                       snd_idle_pct = 0;
    int                       rcv_stall_pct = 0;
    int                       hold_tokens = 0;

    chebyshev_series_evaluator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int active_degree(input logic [DEG_W-1:0] d);
        return (d == 0) ? 1 : int'(d);
    endfunction

    function automatic longint round_q29(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 28)) >>> FRAC_SHIFT;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic longint coef_at(input int k);
        return longint'(coef_table[k]);
    endfunction

    function automatic eval_rsp_t chebyshev_sum(input logic signed [ARG_W-1:0] x_in);
        eval_rsp_t r;
        longint    x;
        longint    t_prev;
        longint    t_cur;
        longint    t_raw;
        longint    acc;
        longint    acc_raw;
        int        top;
        bit        sat;
        x = longint'(x_in);
        top = active_degree(degree_reg);
        sat = 1'b0;
        t_prev = longint'(T_ONE);
        t_cur = x;
        acc_raw = round_q29(coef_at(0), t_prev) + round_q29(coef_at(1), t_cur);
        acc = clip(acc_raw, ACC_LO, ACC_HI);
        if (acc != acc_raw)
        begin
            sat = 1'b1;
        end
        for (int k = 2; k <= top; k++)
        begin
            t_raw = 2 * round_q29(x, t_cur) - t_prev;
            t_prev = t_cur;
            t_cur = clip(t_raw, T_LO, T_HI);
            if (t_cur != t_raw)
            begin
                sat = 1'b1;
            end
            acc_raw = acc + round_q29(coef_at(k), t_cur);
            acc = clip(acc_raw, ACC_LO, ACC_HI);
            if (acc != acc_raw)
            begin
                sat = 1'b1;
            end
        end
        r.series_value = acc[ACC_W-1:0];
        r.saturated = sat;
        return r;
    endfunction

    task automatic record(input eval_req_t it, input bit typed, input eval_rsp_t want);
        if (it.operation == OP_LOAD)
        begin
            coef_table[it.coefficient_index] = it.coefficient_value;
            coef_loaded[it.coefficient_index] = 1'b1;
        end
        else
        begin
            pending_sums.insert(pending_sums.size(), typed ? want : chebyshev_sum(it.argument));
        end
    endtask

    task automatic add_row(input logic op, input logic [5:0] idx, input logic [31:0] coef,
                           input logic [31:0] arg, input bit typed,
                           input logic signed [47:0] value, input logic sat);
        stim_row_t row;
        row.item.operation = op;
        row.item.coefficient_index = idx;
        row.item.coefficient_value = coef;
        row.item.argument = arg;
        row.typed = typed;
        row.want.series_value = value;
        row.want.saturated = sat;
        stim_table.insert(stim_table.size(), row);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return int'($urandom_range(0, 33554432)) - 16777216;
        endcase
    endfunction

    function automatic logic [31:0] pick_argument();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h2000_0000;
                    default: return 32'hE000_0000;
                endcase
            end
            default: return int'($urandom_range(0, 1073741824)) - 536870912;
        endcase
    endfunction

    function automatic eval_req_t make_item();
        eval_req_t it;
        int        top;
        it.operation = ($urandom_range(0, 99) < 45) ? OP_EVAL : OP_LOAD;
        it.coefficient_index = IDX_IN_W'($urandom_range(0, 63));
        it.coefficient_value = pick_coef();
        it.argument = pick_argument();
        if (it.operation == OP_EVAL)
        begin
            top = active_degree(degree_reg);
            for (int k = top; k >= 0; k--)
            begin
                if (!coef_loaded[k])
                begin
                    it.operation = OP_LOAD;
                    it.coefficient_index = IDX_IN_W'(k);
                end
            end
        end
        return it;
    endfunction

    function automatic logic [DEG_W-1:0] phase_degree(input int p);
        case (p)
            0:       return 0;
            1:       return 63;
            2:       return 5;
            3:       return 2;
            4:       return 31;
            5:       return 1;
            6:       return 17;
            7:       return 3;
            default: return 9;
        endcase
    endfunction

    task automatic offer(input eval_req_t it);
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        req <= it;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic wait_drained();
        while (pending_sums.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_degree(input logic [DEG_W-1:0] d);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= d;
        degree_reg = d;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        eval_rsp_t want;
        int        hold_left;
        int        hold_seen;
        hold_left = 0;
        hold_seen = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_sums.size() == 0)
                begin
                    report_mismatch("unexpected result", longint'(rsp.series_value), 0);
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (rsp.series_value !== want.series_value)
                    begin
                        report_mismatch("series_value", longint'(rsp.series_value),
                                        longint'(want.series_value));
                    end
                    if (rsp.saturated !== want.saturated)
                    begin
                        report_mismatch("saturated", longint'(rsp.saturated),
                                        longint'(want.saturated));
                    end
                end
            end
            if (hold_seen != hold_tokens)
            begin
                hold_seen = hold_tokens;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
            end
        end
    end

    initial
    begin
        eval_req_t it;
        eval_rsp_t none;
        none = '0;
        foreach (coef_table[k])
        begin
            coef_table[k] = '0;
            coef_loaded[k] = 1'b0;
        end

        // degree 1 after reset: c0 + c1*x, exact values where easy
        add_row(OP_LOAD, 0,  32'h0080_0000, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(OP_LOAD, 1,  32'h0000_0000, 32'h0000_0000, 0, 0, 0);
        add_row(OP_EVAL, 63, 32'h7FFF_FFFF, 32'h1234_5678, 1, 48'sd8388608, 0);
        add_row(OP_LOAD, 1,  32'h0080_0000, 32'h8000_0000, 0, 0, 0);
        add_row(OP_LOAD, 0,  32'h0000_0000, 32'h0000_0000, 0, 0, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'h2000_0000, 1, 48'sd8388608, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'hE000_0000, 1, -48'sd8388608, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'h0000_0000, 1, 48'sd0, 0);
        // round half up, both signs
        add_row(OP_LOAD, 1,  32'h0000_0001, 32'h0000_0000, 0, 0, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'h1000_0000, 1, 48'sd1, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'h0FFF_FFFF, 1, 48'sd0, 0);
        add_row(OP_LOAD, 1,  32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'h1000_0000, 1, 48'sd0, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'h1000_0001, 1, -48'sd1, 0);
        // field extremes
        add_row(OP_LOAD, 0,  32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
        add_row(OP_LOAD, 1,  32'h8000_0000, 32'h0000_0000, 0, 0, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'h8000_0000, 1, 48'sd6442450944, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'h7FFF_FFFF, 1, -48'sd10737418236, 0);
        add_row(OP_LOAD, 0,  32'h7FFF_FFFF, 32'h0000_0000, 0, 0, 0);
        add_row(OP_LOAD, 1,  32'h7FFF_FFFF, 32'h0000_0000, 0, 0, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'h7FFF_FFFF, 1, 48'sd10737418231, 0);
        add_row(OP_EVAL, 0,  32'h0000_0000, 32'h8000_0000, 1, -48'sd6442450941, 0);
        add_row(OP_LOAD, 63, 32'h0040_0000, 32'h5555_5555, 0, 0, 0);
        add_row(OP_EVAL, 42, 32'hDEAD_BEEF, 32'h1000_0000, 0, 0, 0);
        add_row(OP_EVAL, 21, 32'h1234_5678, 32'hC000_0000, 0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            offer(stim_table[i].item);
            record(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
        end
        req_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            set_degree(phase_degree(p));
            case (p / 3)
                0:
                begin
                    snd_idle_pct = 38;
                    rcv_stall_pct <= 70;
                end
                1:
                begin
                    snd_idle_pct = 70;
                    rcv_stall_pct <= 38;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_stall_pct <= 0;
                end
            endcase
            // long receiver hold-off with the sender still pushing
            if (p == 6)
            begin
                hold_tokens <= hold_tokens + 1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 4 && n == PHASE_ITEMS / 2)
                begin
                    req_valid <= 1'b0;
                    wait_drained();
                end
                it = make_item();
                offer(it);
                record(it, 1'b0, none);
            end
            req_valid <= 1'b0;
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
